>>> rtl/cube_root_newton_top_macros.svh
// ----------------------------------------------------------------------------
// cube_root_newton_top_macros.svh
// Assertion macros shared by the cube root checker.
// ----------------------------------------------------------------------------
`ifndef CUBE_ROOT_NEWTON_TOP_MACROS_SVH
`define CUBE_ROOT_NEWTON_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define CBRT_ASSERT_IMP(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define CBRT_ASSERT_NXT(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

>>> rtl/cbrt_pkg.sv
// ----------------------------------------------------------------------------
// cbrt_pkg
// Types, widths and constants of the Newton cube root block.
// ----------------------------------------------------------------------------
package cbrt_pkg;

  localparam int VALUE_W = 32;   // input, signed Q16.16
  localparam int ROOT_W  = 23;   // result, signed Q7.16
  localparam int MAG_W   = 22;   // saturated result magnitude
  localparam int TOL_W   = 16;
  localparam int ITER_W  = 7;
  localparam int X_W     = 40;   // estimate and divider remainder
  localparam int DVD_W   = 48;   // dividend / quotient shift register
  localparam int SUM_W   = 42;   // q + 2x
  localparam int CNT_W   = 6;

  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam int DIV1_STEPS  = 48;  // m * 2^16 / x
  localparam int DIV2_STEPS  = 40;  // t * 2^16 / x, top 24 quotient bits known zero
  localparam int DIV3_STEPS  = 7;   // (q + 2x) / 3, six digits per cycle
  localparam int DIV3_DIGITS = 6;

  localparam logic [VALUE_W-1:0] ONE_Q16   = 32'h0001_0000;
  localparam logic [X_W-1:0]     QUOT_CAP  = 40'hFF_FFFF_FFFF;
  localparam logic [X_W-1:0]     ROOT_MAX  = 40'h00_0020_0000;

  localparam logic [TOL_W-1:0]  TOL_RESET  = 16'd1;
  localparam logic [ITER_W-1:0] ITER_RESET = 7'd100;

  typedef enum logic {
    REG_TOLERANCE = 1'b0,
    REG_MAX_ITER  = 1'b1
  } reg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_DIV1,
    ST_LOAD2,
    ST_DIV2,
    ST_LOAD3,
    ST_DIV3,
    ST_UPDATE,
    ST_FINISH,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic load_in;
    logic load_div1;
    logic div_step;
    logic load_div2;
    logic load_div3;
    logic div3_step;
    logic update;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic mag_zero;
    logic step_conv;
  } status_t;

endpackage

>>> rtl/cbrt_regs.sv
// ----------------------------------------------------------------------------
// cbrt_regs
// APB register file: tolerance and iteration limit.
// ----------------------------------------------------------------------------
module cbrt_regs (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel_i,
  input  logic                              penable_i,
  input  logic                              pwrite_i,
  input  logic [cbrt_pkg::PADDR_W-1:0]      paddr_i,
  input  logic [cbrt_pkg::PDATA_W-1:0]      pwdata_i,
  output logic [cbrt_pkg::PDATA_W-1:0]      prdata_o,
  output logic                              pready_o,
  output logic [cbrt_pkg::TOL_W-1:0]        tolerance_o,
  output logic [cbrt_pkg::ITER_W-1:0]       max_iter_o
);

  logic                        wr_en;
  cbrt_pkg::reg_idx_e          idx;
  logic [cbrt_pkg::TOL_W-1:0]  tol_q;
  logic [cbrt_pkg::ITER_W-1:0] max_iter_q;

  // registers sit on 4-byte words; bit 2 selects
  assign idx      = cbrt_pkg::reg_idx_e'(paddr_i[2]);
  assign wr_en    = psel_i & penable_i & pwrite_i;
  assign pready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q      <= cbrt_pkg::TOL_RESET;
      max_iter_q <= cbrt_pkg::ITER_RESET;
    end else if (wr_en) begin
      case (idx)
        cbrt_pkg::REG_TOLERANCE: tol_q      <= pwdata_i[cbrt_pkg::TOL_W-1:0];
        cbrt_pkg::REG_MAX_ITER:  max_iter_q <= pwdata_i[cbrt_pkg::ITER_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      cbrt_pkg::REG_TOLERANCE:
        prdata_o = {{(cbrt_pkg::PDATA_W-cbrt_pkg::TOL_W){1'b0}}, tol_q};
      cbrt_pkg::REG_MAX_ITER:
        prdata_o = {{(cbrt_pkg::PDATA_W-cbrt_pkg::ITER_W){1'b0}}, max_iter_q};
      default:
        prdata_o = '0;
    endcase
  end

  assign tolerance_o = tol_q;
  assign max_iter_o  = max_iter_q;

endmodule

>>> rtl/cbrt_dp.sv
// ----------------------------------------------------------------------------
// cbrt_dp
// Datapath: magnitude, estimate, bit-serial divider, divide-by-3, result.
// ----------------------------------------------------------------------------
module cbrt_dp (
  input  logic                               clk_i,
  input  cbrt_pkg::cmd_t                     cmd_i,
  input  logic signed [cbrt_pkg::VALUE_W-1:0] value_i,
  input  logic [cbrt_pkg::TOL_W-1:0]         tolerance_i,
  output cbrt_pkg::status_t                  status_o,
  output logic signed [cbrt_pkg::ROOT_W-1:0] root_o
);

  localparam int XW = cbrt_pkg::X_W;
  localparam int DW = cbrt_pkg::DVD_W;

  logic                               neg_q, neg_d;
  logic [cbrt_pkg::VALUE_W-1:0]       m_q, m_d;
  logic [XW-1:0]                      x_q, x_d;
  logic [XW-1:0]                      rem_q, rem_d;
  logic [DW-1:0]                      dvd_q, dvd_d;
  logic                               sat_q, sat_d;
  logic [1:0]                         r3_q, r3_d;
  logic signed [cbrt_pkg::ROOT_W-1:0] root_q, root_d;

  logic [cbrt_pkg::VALUE_W-1:0] mag_in;
  logic [XW-1:0]                x_init;
  logic [XW:0]                  r_sh, r_sub;
  logic                         q_bit;
  logic [XW-1:0]                rem_step;
  logic [23:0]                  t_hi;
  logic [XW-1:0]                q_sat;
  logic [cbrt_pkg::SUM_W-1:0]   sum;
  logic [cbrt_pkg::DIV3_DIGITS-1:0] q3;
  logic [1:0]                   r3_step;
  logic [2:0]                   v3;
  logic [XW-1:0]                nx, diff;
  logic [cbrt_pkg::MAG_W-1:0]   mag_sat;
  logic [cbrt_pkg::ROOT_W-1:0]  mag_ext;

  // magnitude of the input; the most negative value maps to 2^31
  assign mag_in = value_i[cbrt_pkg::VALUE_W-1] ? (~value_i + 32'd1) : value_i;
  assign x_init = (mag_in > cbrt_pkg::ONE_Q16) ? {8'd0, mag_in}
                                              : {8'd0, cbrt_pkg::ONE_Q16};

  // restoring divider, one quotient bit per cycle
  assign r_sh     = {rem_q, dvd_q[DW-1]};
  assign r_sub    = r_sh - {1'b0, x_q};
  assign q_bit    = (r_sh >= {1'b0, x_q});
  assign rem_step = q_bit ? r_sub[XW-1:0] : r_sh[XW-1:0];

  // second pass starts from t >> 24; quotient saturates if that is >= x
  assign t_hi  = dvd_q[DW-1:24];
  assign q_sat = sat_q ? cbrt_pkg::QUOT_CAP : dvd_q[XW-1:0];
  assign sum   = {2'b00, q_sat} + {1'b0, x_q, 1'b0};

  // divide by 3, six digits per cycle, 2-bit remainder
  always_comb begin
    r3_step = r3_q;
    v3      = '0;
    q3      = '0;
    for (int k = 0; k < cbrt_pkg::DIV3_DIGITS; k++) begin
      v3 = {r3_step, dvd_q[DW-1-k]};
      q3[cbrt_pkg::DIV3_DIGITS-1-k] = (v3 >= 3'd3);
      r3_step = (v3 >= 3'd3) ? 2'(v3 - 3'd3) : v3[1:0];
    end
  end

  // new estimate and convergence test
  assign nx   = dvd_q[XW-1:0];
  assign diff = (nx > x_q) ? (nx - x_q) : (x_q - nx);

  assign status_o.mag_zero  = (m_q == '0);
  assign status_o.step_conv = (diff < {{(XW-cbrt_pkg::TOL_W){1'b0}}, tolerance_i});

  // result magnitude saturates at 32.0
  assign mag_sat = (x_q > cbrt_pkg::ROOT_MAX) ? cbrt_pkg::ROOT_MAX[cbrt_pkg::MAG_W-1:0]
                                             : x_q[cbrt_pkg::MAG_W-1:0];
  assign mag_ext = {1'b0, mag_sat};

  always_comb begin
    neg_d  = neg_q;
    m_d    = m_q;
    x_d    = x_q;
    rem_d  = rem_q;
    dvd_d  = dvd_q;
    sat_d  = sat_q;
    r3_d   = r3_q;
    root_d = root_q;
    if (cmd_i.load_in) begin
      neg_d = value_i[cbrt_pkg::VALUE_W-1];
      m_d   = mag_in;
      x_d   = x_init;
    end
    if (cmd_i.update) begin
      x_d = nx;
    end
    if (cmd_i.load_div1) begin
      rem_d = '0;
      dvd_d = {m_q, 16'd0};
    end
    if (cmd_i.div_step) begin
      rem_d = rem_step;
      dvd_d = {dvd_q[DW-2:0], q_bit};
    end
    if (cmd_i.load_div2) begin
      sat_d = ({16'd0, t_hi} >= x_q);
      rem_d = {16'd0, t_hi};
      dvd_d = {dvd_q[23:0], 24'd0};
    end
    if (cmd_i.load_div3) begin
      r3_d  = '0;
      dvd_d = {sum, {cbrt_pkg::DIV3_DIGITS{1'b0}}};
    end
    if (cmd_i.div3_step) begin
      r3_d  = r3_step;
      dvd_d = {dvd_q[DW-1-cbrt_pkg::DIV3_DIGITS:0], q3};
    end
    if (cmd_i.finish) begin
      if (m_q == '0) begin
        root_d = '0;
      end else if (neg_q) begin
        root_d = $signed(~mag_ext + 23'd1);
      end else begin
        root_d = $signed(mag_ext);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q  <= neg_d;
    m_q    <= m_d;
    x_q    <= x_d;
    rem_q  <= rem_d;
    dvd_q  <= dvd_d;
    sat_q  <= sat_d;
    r3_q   <= r3_d;
    root_q <= root_d;
  end

  assign root_o = root_q;

endmodule

>>> rtl/cbrt_ctrl.sv
// ----------------------------------------------------------------------------
// cbrt_ctrl
// Sequencer: walks each Newton step through the divider passes.
// ----------------------------------------------------------------------------
module cbrt_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [cbrt_pkg::ITER_W-1:0] max_iter_i,
  input  cbrt_pkg::status_t           status_i,
  output cbrt_pkg::cmd_t              cmd_o,
  output logic                        busy_o,
  output logic                        result_valid_o,
  output logic                        converged_o
);

  localparam int CW = cbrt_pkg::CNT_W;

  cbrt_pkg::state_e            state_q, state_d;
  logic [CW-1:0]               cnt_q, cnt_d;
  logic [cbrt_pkg::ITER_W-1:0] iter_q, iter_d;
  logic                        conv_q, conv_d;
  logic [cbrt_pkg::ITER_W:0]   iter_inc;

  assign iter_inc = {1'b0, iter_q} + 1'b1;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      cbrt_pkg::ST_IDLE:   if (start_i) state_d = cbrt_pkg::ST_INIT;
      cbrt_pkg::ST_INIT: begin
        if (status_i.mag_zero || (max_iter_i == '0)) state_d = cbrt_pkg::ST_FINISH;
        else                                         state_d = cbrt_pkg::ST_DIV1;
      end
      cbrt_pkg::ST_DIV1:
        if (cnt_q == CW'(cbrt_pkg::DIV1_STEPS - 1)) state_d = cbrt_pkg::ST_LOAD2;
      cbrt_pkg::ST_LOAD2:  state_d = cbrt_pkg::ST_DIV2;
      cbrt_pkg::ST_DIV2:
        if (cnt_q == CW'(cbrt_pkg::DIV2_STEPS - 1)) state_d = cbrt_pkg::ST_LOAD3;
      cbrt_pkg::ST_LOAD3:  state_d = cbrt_pkg::ST_DIV3;
      cbrt_pkg::ST_DIV3:
        if (cnt_q == CW'(cbrt_pkg::DIV3_STEPS - 1)) state_d = cbrt_pkg::ST_UPDATE;
      cbrt_pkg::ST_UPDATE: begin
        if (status_i.step_conv || (iter_inc == {1'b0, max_iter_i}))
          state_d = cbrt_pkg::ST_FINISH;
        else
          state_d = cbrt_pkg::ST_DIV1;
      end
      cbrt_pkg::ST_FINISH: state_d = cbrt_pkg::ST_DONE;
      cbrt_pkg::ST_DONE:   state_d = cbrt_pkg::ST_IDLE;
      default:             state_d = cbrt_pkg::ST_IDLE;
    endcase
  end

  // bit counter, iteration count, convergence flag
  always_comb begin
    cnt_d  = '0;
    iter_d = iter_q;
    conv_d = conv_q;
    case (state_q)
      cbrt_pkg::ST_DIV1, cbrt_pkg::ST_DIV2, cbrt_pkg::ST_DIV3:
        cnt_d = (state_d == state_q) ? cnt_q + 1'b1 : '0;
      cbrt_pkg::ST_INIT: begin
        iter_d = '0;
        conv_d = status_i.mag_zero;
      end
      cbrt_pkg::ST_UPDATE: begin
        iter_d = iter_inc[cbrt_pkg::ITER_W-1:0];
        conv_d = status_i.step_conv;
      end
      default: ;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o          = '0;
    busy_o         = 1'b1;
    result_valid_o = 1'b0;
    case (state_q)
      cbrt_pkg::ST_IDLE: begin
        busy_o        = 1'b0;
        cmd_o.load_in = start_i;
      end
      cbrt_pkg::ST_INIT:   cmd_o.load_div1 = 1'b1;
      cbrt_pkg::ST_DIV1:   cmd_o.div_step  = 1'b1;
      cbrt_pkg::ST_LOAD2:  cmd_o.load_div2 = 1'b1;
      cbrt_pkg::ST_DIV2:   cmd_o.div_step  = 1'b1;
      cbrt_pkg::ST_LOAD3:  cmd_o.load_div3 = 1'b1;
      cbrt_pkg::ST_DIV3:   cmd_o.div3_step = 1'b1;
      cbrt_pkg::ST_UPDATE: begin
        cmd_o.update    = 1'b1;
        cmd_o.load_div1 = 1'b1;
      end
      cbrt_pkg::ST_FINISH: cmd_o.finish = 1'b1;
      cbrt_pkg::ST_DONE:   result_valid_o = 1'b1;
      default:             busy_o = 1'b1;
    endcase
  end

  assign converged_o = conv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cbrt_pkg::ST_IDLE;
      cnt_q   <= '0;
      iter_q  <= '0;
      conv_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      iter_q  <= iter_d;
      conv_q  <= conv_d;
    end
  end

endmodule

>>> rtl/cube_root_newton_top.sv
// ----------------------------------------------------------------------------
// cube_root_newton_top - Newton-Raphson cube root of a signed Q16.16 value.
// A zero input skips the Newton steps on its way to the result strobe; other
//   inputs run N Newton steps first (N <= max_iterations, up to 127).
// One item at a time; start is taken again the cycle after the strobe.
// Each step is bound by the 1-bit-per-cycle divider: 48 + 40 bit passes.
// Reset (rst_ni low, async): idle, tolerance = 1, max_iterations = 100.
// ----------------------------------------------------------------------------
//
// Data flow per item:
//   accept: magnitude m and sign latched, estimate x = max(m, 1.0).
//   step:   t = m*2^16 / x           (48 quotient bits, shared divider)
//           q = t*2^16 / x           (40 quotient bits; the divider starts
//                                     from t >> 24, and q saturates to
//                                     2^40-1 when t >> 24 is not below x)
//           x' = (q + 2x) / 3        (digit-serial, 6 digits per cycle)
//           stop when |x' - x| < tolerance or the step count hits the limit.
//   finish: magnitude clamped at 32.0, sign restored, one-cycle strobe.
// The receiver takes each result in the strobe cycle; no back-pressure.
// Configuration writes are expected only while busy is low.
module cube_root_newton_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // item channel
  input  logic                                start,
  output logic                                busy,
  input  logic signed [cbrt_pkg::VALUE_W-1:0] value_i,
  // result channel
  output logic                                result_valid_o,
  output logic signed [cbrt_pkg::ROOT_W-1:0]  root_o,
  output logic                                converged_o,
  // APB configuration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [cbrt_pkg::PADDR_W-1:0]        paddr,
  input  logic [cbrt_pkg::PDATA_W-1:0]        pwdata,
  output logic [cbrt_pkg::PDATA_W-1:0]        prdata,
  output logic                                pready
);

  logic [cbrt_pkg::TOL_W-1:0]  tolerance;
  logic [cbrt_pkg::ITER_W-1:0] max_iter;
  cbrt_pkg::cmd_t              cmd;
  cbrt_pkg::status_t           status;

  // tolerance at word 0, iteration limit at word 1
  cbrt_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel_i      (psel),
    .penable_i   (penable),
    .pwrite_i    (pwrite),
    .paddr_i     (paddr),
    .pwdata_i    (pwdata),
    .prdata_o    (prdata),
    .pready_o    (pready),
    .tolerance_o (tolerance),
    .max_iter_o  (max_iter)
  );

  // sequencer: owns the bit counter, step count and convergence flag
  cbrt_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .max_iter_i     (max_iter),
    .status_i       (status),
    .cmd_o          (cmd),
    .busy_o         (busy),
    .result_valid_o (result_valid_o),
    .converged_o    (converged_o)
  );

  // arithmetic: estimate, shared divider, divide-by-3, result register
  cbrt_dp u_dp (
    .clk_i       (clk_i),
    .cmd_i       (cmd),
    .value_i     (value_i),
    .tolerance_i (tolerance),
    .status_o    (status),
    .root_o      (root_o)
  );

endmodule

>>> rtl/cube_root_newton_top_chk.sv
// ----------------------------------------------------------------------------
// cube_root_newton_top_chk
// Port-level checks of the cube root block, bound to the top level.
// ----------------------------------------------------------------------------
`include "cube_root_newton_top_macros.svh"

module cube_root_newton_top_chk (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                start,
  input logic                                busy,
  input logic signed [cbrt_pkg::VALUE_W-1:0] value_i,
  input logic                                result_valid_o,
  input logic signed [cbrt_pkg::ROOT_W-1:0]  root_o,
  input logic                                converged_o
);

  // an accepted item keeps the block busy
  `CBRT_ASSERT_NXT(a_accept_busy, start && !busy, busy, "busy low after accept")

  // one strobe per item
  `CBRT_ASSERT_NXT(a_strobe_single, result_valid_o, !result_valid_o, "strobe held")

  // a result only while an item is in flight
  `CBRT_ASSERT_IMP(a_strobe_busy, result_valid_o, busy, "strobe while idle")

  // zero input answers zero, converged, on the short path
  `CBRT_ASSERT_IMP(a_zero_item, result_valid_o && $past(start && !busy && value_i == 0, 3), (root_o == 0) && converged_o, "zero item result")

endmodule

bind cube_root_newton_top cube_root_newton_top_chk u_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .value_i        (value_i),
  .result_valid_o (result_valid_o),
  .root_o         (root_o),
  .converged_o    (converged_o)
);
